>>> hw/rtl/multicycle_mips_subset_core_defines.svh
// assertion macros shared by the multicycle core rtl
`ifndef MULTICYCLE_MIPS_SUBSET_CORE_DEFINES_SVH
`define MULTICYCLE_MIPS_SUBSET_CORE_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define MMSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked only out of reset
`define MMSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mmsc_pkg.sv
// types, constants and state codes of the multicycle core
`default_nettype none

package mmsc_pkg;

    // main memory depth, a power of two
    localparam int MEM_DEPTH = 1024;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int REG_COUNT = 32;
    localparam int RF_AW     = $clog2(REG_COUNT);
    localparam int LOAD_AW   = 10;
    localparam int WORD_W    = 32;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [MEM_AW-1:0]  mem_addr_t;
    typedef logic [RF_AW-1:0]   rf_addr_t;
    typedef logic [3:0]         state_t;
    typedef logic [5:0]         opcode_t;
    typedef logic [3:0]         funct_t;

    // textbook control state numbering
    localparam state_t S_FETCH    = 4'd0;
    localparam state_t S_DECODE   = 4'd1;
    localparam state_t S_ADDR     = 4'd2;
    localparam state_t S_MEM_RD   = 4'd3;
    localparam state_t S_LOAD_WB  = 4'd4;
    localparam state_t S_MEM_WR   = 4'd5;
    localparam state_t S_RTYPE_EX = 4'd6;
    localparam state_t S_RTYPE_WB = 4'd7;
    localparam state_t S_BRANCH   = 4'd8;
    localparam state_t S_JUMP     = 4'd9;

    localparam opcode_t OP_RTYPE = 6'h00;
    localparam opcode_t OP_JUMP  = 6'h02;
    localparam opcode_t OP_BEQ   = 6'h04;
    localparam opcode_t OP_LW    = 6'h23;
    localparam opcode_t OP_SW    = 6'h2b;

    localparam funct_t FN_ADD = 4'h0;
    localparam funct_t FN_SUB = 4'h2;
    localparam funct_t FN_AND = 4'h4;
    localparam funct_t FN_OR  = 4'h5;
    localparam funct_t FN_SLT = 4'hA;

    // operation selector of an input transaction
    localparam logic OPN_STEP = 1'b0;
    localparam logic OPN_LOAD = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [LOAD_AW-1:0] load_address;
        word_t              load_data;
    } item_t;

    typedef struct packed {
        word_t  pc_value;
        state_t fsm_state;
        logic   halted;
        logic   bad_opcode;
    } result_t;

    typedef struct packed {
        logic      en;
        mem_addr_t addr;
        word_t     data;
    } mem_wr_t;

    typedef struct packed {
        logic     en;
        rf_addr_t addr;
        word_t    data;
    } rf_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/multicycle_mips_subset_core.sv
// Multicycle core for a MIPS subset (add, sub, and, or, slt, lw, sw, beq, j).
// Input channel s_*: each transaction either advances the control state machine
// by one machine cycle (s_tuser = 0) or writes one word of main memory
// (s_tuser = 1, address and data in s_tdata). Result channel m_*: exactly one
// transaction per input transaction, carrying the PC, the control state now
// entered and the halted and bad-opcode flags.
// The item is taken into the input register at the accepting edge and sits there while
// the state machine works on it; the result register loads when the item is consumed,
// and m_tvalid rises with it.
// Throughput is one transaction per clock while m_tready is high; memory and register-file
// reads are issued on the edge that enters a state, so the data is registered in time.
// Reset clears the PC, the internal registers, the register file (by valid bits)
// and both flags, and puts the machine in fetch; main memory holds nothing
// defined until written. When m_tready is low, the result register holds, one
// more transaction waits in the input register and s_tready then drops.
// A zero instruction word halts the core and an unknown opcode stops it in
// decode; after either, step transactions change nothing until reset.
`default_nettype none
`include "multicycle_mips_subset_core_defines.svh"

module multicycle_mips_subset_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // load_address[9:0], load_data[41:10], zero pad
    input  wire logic [0:0]  s_tuser,   // operation[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // pc_value[31:0], fsm_state[35:32], halted[36],
                                        // bad_opcode[37], zero pad
);

    logic                in_valid_reg;
    mmsc_pkg::item_t     in_item_reg;
    logic                out_valid_reg;
    mmsc_pkg::result_t   out_reg;
    logic                consume;

    mmsc_pkg::mem_wr_t   mem_wr;
    mmsc_pkg::mem_addr_t mem_raddr;
    mmsc_pkg::word_t     mem_rdata;
    mmsc_pkg::rf_wr_t    rf_wr;
    mmsc_pkg::rf_addr_t  rf_raddr_a;
    mmsc_pkg::rf_addr_t  rf_raddr_b;
    mmsc_pkg::word_t     rf_rdata_a;
    mmsc_pkg::word_t     rf_rdata_b;
    mmsc_pkg::result_t   result_next;

    // the held item runs once the result register is free or being emptied
    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (consume) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= '{operation: s_tuser[0],
                             load_address: s_tdata[9:0],
                             load_data: s_tdata[41:10]};
        end
        if (consume) begin
            out_reg <= result_next;
        end
    end

    mmsc_exec u_exec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .go          (consume),
        .item        (in_item_reg),
        .mem_rdata   (mem_rdata),
        .rf_rdata_a  (rf_rdata_a),
        .rf_rdata_b  (rf_rdata_b),
        .mem_wr      (mem_wr),
        .mem_raddr   (mem_raddr),
        .rf_wr       (rf_wr),
        .rf_raddr_a  (rf_raddr_a),
        .rf_raddr_b  (rf_raddr_b),
        .result_next (result_next)
    );

    mmsc_main_mem u_main_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (mem_wr),
        .raddr   (mem_raddr),
        .rdata   (mem_rdata)
    );

    mmsc_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (rf_wr),
        .raddr_a (rf_raddr_a),
        .raddr_b (rf_raddr_b),
        .rdata_a (rf_rdata_a),
        .rdata_b (rf_rdata_b)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.bad_opcode, out_reg.halted,
                       out_reg.fsm_state, out_reg.pc_value};

    `MMSC_ASSERT_NOW(a_halt_in_fetch, aclk, aresetn, m_tvalid && out_reg.halted,
        out_reg.fsm_state == mmsc_pkg::S_FETCH, "halted core left fetch")
    `MMSC_ASSERT_NOW(a_bad_in_decode, aclk, aresetn, m_tvalid && out_reg.bad_opcode,
        out_reg.fsm_state == mmsc_pkg::S_DECODE, "bad opcode outside decode")
    `MMSC_ASSERT_NEXT(a_consume_fills, aclk, aresetn, consume,
        out_valid_reg, "consumed transaction produced no result")
    `MMSC_ASSERT_NEXT(a_halt_sticky, aclk, aresetn,
        consume && result_next.halted && out_valid_reg,
        result_next.halted, "halted flag cleared without reset")

endmodule

`default_nettype wire

>>> hw/rtl/mmsc_main_mem.sv
// main memory: one write port, one registered read port with write bypass
`default_nettype none

module mmsc_main_mem (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mmsc_pkg::mem_wr_t   wr,
    input  wire mmsc_pkg::mem_addr_t raddr,
    output mmsc_pkg::word_t          rdata
);

    mmsc_pkg::word_t mem [mmsc_pkg::MEM_DEPTH];
    mmsc_pkg::word_t raw_reg;
    mmsc_pkg::word_t fwd_data_reg;
    logic            fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        raw_reg      <= mem[raddr];
        fwd_data_reg <= wr.data;
    end

    // a write to the address being read this edge wins over the old word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else begin
            fwd_hit_reg <= wr.en && (wr.addr == raddr);
        end
    end

    assign rdata = fwd_hit_reg ? fwd_data_reg : raw_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mmsc_regfile.sv
// register file: two registered read ports, one write port, cleared by valid bits
`default_nettype none

module mmsc_regfile (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mmsc_pkg::rf_wr_t   wr,
    input  wire mmsc_pkg::rf_addr_t raddr_a,
    input  wire mmsc_pkg::rf_addr_t raddr_b,
    output mmsc_pkg::word_t         rdata_a,
    output mmsc_pkg::word_t         rdata_b
);

    mmsc_pkg::word_t                  rf_mem [mmsc_pkg::REG_COUNT];
    logic [mmsc_pkg::REG_COUNT-1:0]   valid_reg;
    mmsc_pkg::word_t                  raw_a_reg;
    mmsc_pkg::word_t                  raw_b_reg;
    mmsc_pkg::word_t                  fwd_data_reg;
    logic                             fwd_a_reg;
    logic                             fwd_b_reg;
    logic                             zero_a_reg;
    logic                             zero_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            rf_mem[wr.addr] <= wr.data;
        end
        raw_a_reg    <= rf_mem[raddr_a];
        raw_b_reg    <= rf_mem[raddr_b];
        fwd_data_reg <= wr.data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            fwd_a_reg  <= 1'b0;
            fwd_b_reg  <= 1'b0;
            zero_a_reg <= 1'b1;
            zero_b_reg <= 1'b1;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            fwd_a_reg  <= wr.en && (wr.addr == raddr_a);
            fwd_b_reg  <= wr.en && (wr.addr == raddr_b);
            zero_a_reg <= !valid_reg[raddr_a];
            zero_b_reg <= !valid_reg[raddr_b];
        end
    end

    // never-written registers read as zero
    assign rdata_a = fwd_a_reg ? fwd_data_reg : (zero_a_reg ? '0 : raw_a_reg);
    assign rdata_b = fwd_b_reg ? fwd_data_reg : (zero_b_reg ? '0 : raw_b_reg);

endmodule

`default_nettype wire

>>> hw/rtl/mmsc_exec.sv
// architectural registers and one machine cycle of the control state machine
`default_nettype none

module mmsc_exec (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                go,
    input  wire mmsc_pkg::item_t     item,
    input  wire mmsc_pkg::word_t     mem_rdata,
    input  wire mmsc_pkg::word_t     rf_rdata_a,
    input  wire mmsc_pkg::word_t     rf_rdata_b,
    output mmsc_pkg::mem_wr_t        mem_wr,
    output mmsc_pkg::mem_addr_t      mem_raddr,
    output mmsc_pkg::rf_wr_t         rf_wr,
    output mmsc_pkg::rf_addr_t       rf_raddr_a,
    output mmsc_pkg::rf_addr_t       rf_raddr_b,
    output mmsc_pkg::result_t        result_next
);

    mmsc_pkg::word_t  pc_reg, pc_next;
    mmsc_pkg::word_t  ir_reg, ir_next;
    mmsc_pkg::word_t  mdr_reg, mdr_next;
    mmsc_pkg::word_t  a_reg, a_next;
    mmsc_pkg::word_t  b_reg, b_next;
    mmsc_pkg::word_t  alu_reg, alu_next;
    mmsc_pkg::state_t state_reg, state_next;
    logic             halted_reg, halted_next;
    logic             bad_reg, bad_next;

    mmsc_pkg::opcode_t opcode;
    mmsc_pkg::funct_t  fn;
    mmsc_pkg::word_t   imm_ext;
    mmsc_pkg::word_t   rtype_res;

    assign opcode  = ir_reg[31:26];
    assign fn      = ir_reg[3:0];
    assign imm_ext = {{16{ir_reg[15]}}, ir_reg[15:0]};

    always_comb begin
        case (fn)
            mmsc_pkg::FN_ADD: rtype_res = a_reg + b_reg;
            mmsc_pkg::FN_SUB: rtype_res = a_reg - b_reg;
            mmsc_pkg::FN_AND: rtype_res = a_reg & b_reg;
            mmsc_pkg::FN_OR:  rtype_res = a_reg | b_reg;
            default:          rtype_res = {31'd0, $signed(a_reg) < $signed(b_reg)};
        endcase
    end

    always_comb begin
        pc_next     = pc_reg;
        ir_next     = ir_reg;
        mdr_next    = mdr_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        alu_next    = alu_reg;
        state_next  = state_reg;
        halted_next = halted_reg;
        bad_next    = bad_reg;
        mem_wr      = '{en: 1'b0,
                        addr: mmsc_pkg::mem_addr_t'(item.load_address),
                        data: item.load_data};
        rf_wr       = '{en: 1'b0, addr: ir_reg[20:16], data: mdr_reg};

        if (go && item.operation == mmsc_pkg::OPN_LOAD) begin
            mem_wr.en = 1'b1;
        end else if (go && !halted_reg && !bad_reg) begin
            case (state_reg)
                mmsc_pkg::S_FETCH: begin
                    ir_next  = mem_rdata;
                    mdr_next = mem_rdata;
                    pc_next  = pc_reg + 32'd1;
                    if (mem_rdata == '0) begin
                        halted_next = 1'b1;
                    end else begin
                        state_next = mmsc_pkg::S_DECODE;
                    end
                end
                mmsc_pkg::S_DECODE: begin
                    a_next   = rf_rdata_a;
                    b_next   = rf_rdata_b;
                    alu_next = pc_reg + imm_ext;
                    if (opcode == mmsc_pkg::OP_RTYPE && (fn inside {mmsc_pkg::FN_ADD,
                            mmsc_pkg::FN_SUB, mmsc_pkg::FN_AND, mmsc_pkg::FN_OR,
                            mmsc_pkg::FN_SLT})) begin
                        state_next = mmsc_pkg::S_RTYPE_EX;
                    end else if (opcode == mmsc_pkg::OP_JUMP) begin
                        state_next = mmsc_pkg::S_JUMP;
                    end else if (opcode == mmsc_pkg::OP_BEQ) begin
                        state_next = mmsc_pkg::S_BRANCH;
                    end else if (opcode inside {mmsc_pkg::OP_LW, mmsc_pkg::OP_SW}) begin
                        state_next = mmsc_pkg::S_ADDR;
                    end else begin
                        bad_next = 1'b1;
                    end
                end
                mmsc_pkg::S_ADDR: begin
                    alu_next   = a_reg + imm_ext;
                    state_next = (opcode == mmsc_pkg::OP_LW) ? mmsc_pkg::S_MEM_RD
                                                             : mmsc_pkg::S_MEM_WR;
                end
                mmsc_pkg::S_MEM_RD: begin
                    mdr_next   = mem_rdata;
                    state_next = mmsc_pkg::S_LOAD_WB;
                end
                mmsc_pkg::S_LOAD_WB: begin
                    rf_wr.en   = 1'b1;
                    state_next = mmsc_pkg::S_FETCH;
                end
                mmsc_pkg::S_MEM_WR: begin
                    mem_wr     = '{en: 1'b1,
                                   addr: mmsc_pkg::mem_addr_t'(alu_reg),
                                   data: b_reg};
                    state_next = mmsc_pkg::S_FETCH;
                end
                mmsc_pkg::S_RTYPE_EX: begin
                    alu_next   = rtype_res;
                    state_next = mmsc_pkg::S_RTYPE_WB;
                end
                mmsc_pkg::S_RTYPE_WB: begin
                    rf_wr      = '{en: 1'b1, addr: ir_reg[15:11], data: alu_reg};
                    state_next = mmsc_pkg::S_FETCH;
                end
                mmsc_pkg::S_BRANCH: begin
                    if (a_reg == b_reg) begin
                        pc_next = alu_reg;
                    end
                    state_next = mmsc_pkg::S_FETCH;
                end
                mmsc_pkg::S_JUMP: begin
                    pc_next    = {pc_reg[31:28], ir_reg[27:26] & 2'b00, ir_reg[25:0]};
                    state_next = mmsc_pkg::S_FETCH;
                end
                default: begin
                    state_next = mmsc_pkg::S_FETCH;
                end
            endcase
        end
    end

    // reads are issued for the state being entered, so the data is ready next cycle
    assign mem_raddr  = (state_next == mmsc_pkg::S_MEM_RD) ? mmsc_pkg::mem_addr_t'(alu_next)
                                                           : mmsc_pkg::mem_addr_t'(pc_next);
    assign rf_raddr_a = ir_next[25:21];
    assign rf_raddr_b = ir_next[20:16];

    assign result_next = '{pc_value: pc_next, fsm_state: state_next,
                           halted: halted_next, bad_opcode: bad_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= '0;
            ir_reg     <= '0;
            mdr_reg    <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            alu_reg    <= '0;
            state_reg  <= mmsc_pkg::S_FETCH;
            halted_reg <= 1'b0;
            bad_reg    <= 1'b0;
        end else begin
            pc_reg     <= pc_next;
            ir_reg     <= ir_next;
            mdr_reg    <= mdr_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            alu_reg    <= alu_next;
            state_reg  <= state_next;
            halted_reg <= halted_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

`default_nettype wire
